// ----- rtl/core/srev_pkg.sv -----
`timescale 1ns / 1ps

package srev_pkg;

  localparam int MAX_GROUP_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int CFG_W         = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // input beat accepted this cycle
    logic rd;     // issue a buffer read for the current output position
    logic adv;    // output beat taken, step to the next position
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flush;     // the beat at the input would close a run
    logic run_last;  // the beat being shown ends its run
  } sts_t;

endpackage

// ----- rtl/core/srev_ram.sv -----
`timescale 1ns / 1ps

module srev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/srev_ctrl.sv -----
`timescale 1ns / 1ps

module srev_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  srev_pkg::sts_t sts,
  output srev_pkg::cmd_t cmd
);

  import srev_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.flush) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.run_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/srev_dp.sv -----
`timescale 1ns / 1ps

module srev_dp #(
  parameter int MAX_GROUP = srev_pkg::MAX_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [srev_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic [srev_pkg::VAL_W-1:0]  in_value,
  input  logic                        in_last,
  input  srev_pkg::cmd_t              cmd,
  output srev_pkg::sts_t              sts,
  output logic [srev_pkg::VAL_W-1:0]  out_value,
  output logic                        out_run_end,
  output logic                        out_stream_end
);

  import srev_pkg::*;

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int EW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  logic [CFG_W-1:0] group_size_r;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             rev_r, rev_nxt;
  logic             end_r, end_nxt;
  logic             run_end_r, stream_end_r;

  logic [EW-1:0]    eff_size;
  logic [EW-1:0]    n_in;
  logic             full_hit;
  logic             pos_last;
  logic [CW-1:0]    rd_pos;

  // Sizes of zero act as one; sizes above the buffer depth act as the depth.
  always_comb begin
    if (group_size_r == '0) begin
      eff_size = EW'(1);
    end else if (EW'(group_size_r) > EW'(MAX_GROUP)) begin
      eff_size = EW'(MAX_GROUP);
    end else begin
      eff_size = EW'(group_size_r);
    end
  end

  assign n_in      = EW'(fill_r) + EW'(1);
  assign full_hit  = (n_in >= eff_size);
  assign sts.flush = full_hit || in_last;

  assign pos_last     = (idx_r == n_r - CW'(1));
  assign sts.run_last = run_end_r;
  assign rd_pos       = rev_r ? (n_r - CW'(1) - idx_r) : idx_r;

  always_comb begin
    fill_nxt = fill_r;
    n_nxt    = n_r;
    idx_nxt  = idx_r;
    rev_nxt  = rev_r;
    end_nxt  = end_r;
    if (cmd.load) begin
      if (sts.flush) begin
        fill_nxt = '0;
        n_nxt    = CW'(n_in);
        idx_nxt  = '0;
        rev_nxt  = full_hit;
        end_nxt  = in_last;
      end else begin
        fill_nxt = CW'(n_in);
      end
    end else if (cmd.adv) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= CFG_W'(1);
      fill_r       <= '0;
      n_r          <= '0;
      idx_r        <= '0;
      rev_r        <= 1'b0;
      end_r        <= 1'b0;
      run_end_r    <= 1'b0;
      stream_end_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        group_size_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
      n_r    <= n_nxt;
      idx_r  <= idx_nxt;
      rev_r  <= rev_nxt;
      end_r  <= end_nxt;
      // Flags follow the read so they line up with the registered RAM data.
      if (cmd.rd) begin
        run_end_r    <= pos_last;
        stream_end_r <= pos_last && end_r;
      end
    end
  end

  srev_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_GROUP)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (cmd.rd),
    .rd_addr (rd_pos[AW-1:0]),
    .rd_data (out_value)
  );

  assign out_run_end    = run_end_r;
  assign out_stream_end = stream_end_r;

  a_fill_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_GROUP - 1))
    else $error("fill count reached the buffer depth");

  a_flush_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.flush) |=> (fill_r == '0))
    else $error("fill count not cleared after a run closed");

  a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (idx_r < n_r))
    else $error("read position beyond the run length");

endmodule

// ----- rtl/core/stream_group_reverser.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Ports                     | Contents
// in      | slave     | in_tvalid/tready/tdata/.. | tdata: item_value; tlast: stream_last
// out     | master    | out_tvalid/tready/tdata/..| tdata: out_value; tlast: run_end;
//         |           |                           | tuser: stream_end
// cfg     | write     | cfg_wr_en, cfg_wr_data    | group_size
//
// Input beats that do not close a run are taken one per cycle.
// A beat that closes a run of n values is followed by n output beats; for each, the
// buffer is first read into its output register and then the beat is presented.
// in_tready is low while a run drains; a stalled output beat holds its data.
// Reset is synchronous: it empties the buffer count and sets group_size to 1.
module stream_group_reverser #(
  parameter int MAX_GROUP = srev_pkg::MAX_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [srev_pkg::CFG_W-1:0] cfg_wr_data,  // group_size
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [srev_pkg::VAL_W-1:0] in_tdata,     // [31:0] item_value
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [srev_pkg::VAL_W-1:0] out_tdata,    // [31:0] out_value
  output logic                       out_tlast,
  output logic                       out_tuser     // [0] stream_end
);

  import srev_pkg::*;

  cmd_t cmd;
  sts_t sts;

  srev_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  srev_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_value       (in_tdata),
    .in_last        (in_tlast),
    .cmd            (cmd),
    .sts            (sts),
    .out_value      (out_tdata),
    .out_run_end    (out_tlast),
    .out_stream_end (out_tuser)
  );

endmodule
